// ----- hw/rtl/tsq_pkg.sv -----
`default_nettype none

package tsq_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DATA_W = 32;
    localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [DATA_W-1:0] word_t;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_OVF   = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP,
        S_EMIT
    } state_t;

    // One write port and one read port of a stack memory.
    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        word_t wdata;
        logic  re;
        ptr_t  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsq_ram.sv -----
`default_nettype none

module tsq_ram (
    input  wire logic             clk,
    input  wire tsq_pkg::mem_req_t req,
    output tsq_pkg::word_t        rdata
);
    import tsq_pkg::*;

    word_t mem [STACK_DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tsq_ctrl.sv -----
`default_nettype none

module tsq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire tsq_pkg::word_t    value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output tsq_pkg::word_t         data_out,
    output tsq_pkg::mem_req_t      inbox_req,
    input  wire tsq_pkg::word_t    inbox_rdata,
    output tsq_pkg::mem_req_t      outbox_req,
    input  wire tsq_pkg::word_t    outbox_rdata
);
    import tsq_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    in_cnt_reg, in_cnt_next;
    cnt_t    out_cnt_reg, out_cnt_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg;
    word_t   out_data_reg;
    status_t pend_status_reg;
    word_t   pend_data_reg;

    logic    accept;
    logic    slot_free;
    logic    in_full;
    logic    res_fire;
    status_t res_status;
    word_t   res_data;
    logic    load_out;
    logic    load_pend;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_full   = (in_cnt_reg == cnt_t'(STACK_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_DEQ && out_cnt_reg != '0)
                    begin
                        state_next = S_POP;
                    end
                    else if (func == FUNC_DEQ && in_cnt_reg != '0)
                    begin
                        state_next = S_XFER;
                    end
                    else
                    begin
                        state_next = slot_free ? S_IDLE : S_EMIT;
                    end
                end
            end
            S_XFER:
            begin
                if (in_cnt_reg == '0)
                begin
                    state_next = slot_free ? S_IDLE : S_EMIT;
                end
            end
            S_POP:
            begin
                state_next = slot_free ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        inbox_req   = '0;
        outbox_req  = '0;
        in_cnt_next = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        res_fire    = 1'b0;
        res_status  = ST_EMPTY;
        res_data    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_ENQ)
                    begin
                        res_fire = 1'b1;
                        if (in_full)
                        begin
                            res_status = ST_OVF;
                        end
                        else
                        begin
                            res_status      = ST_ENQ;
                            inbox_req.we    = 1'b1;
                            inbox_req.waddr = in_cnt_reg[PTR_W-1:0];
                            inbox_req.wdata = value;
                            in_cnt_next     = in_cnt_reg + 1'b1;
                        end
                    end
                    else if (out_cnt_reg != '0)
                    begin
                        outbox_req.re    = 1'b1;
                        outbox_req.raddr = ptr_t'(out_cnt_reg - 1'b1);
                        out_cnt_next     = out_cnt_reg - 1'b1;
                    end
                    else if (in_cnt_reg != '0)
                    begin
                        inbox_req.re    = 1'b1;
                        inbox_req.raddr = ptr_t'(in_cnt_reg - 1'b1);
                        in_cnt_next     = in_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_EMPTY;
                    end
                end
            end
            S_XFER:
            begin
                if (in_cnt_reg != '0)
                begin
                    outbox_req.we    = 1'b1;
                    outbox_req.waddr = out_cnt_reg[PTR_W-1:0];
                    outbox_req.wdata = inbox_rdata;
                    out_cnt_next     = out_cnt_reg + 1'b1;
                    inbox_req.re     = 1'b1;
                    inbox_req.raddr  = ptr_t'(in_cnt_reg - 1'b1);
                    in_cnt_next      = in_cnt_reg - 1'b1;
                end
                else
                begin
                    // The oldest value would land on top of the outbox and be
                    // popped at once, so it goes straight to the result.
                    res_fire   = 1'b1;
                    res_status = ST_DEQ;
                    res_data   = inbox_rdata;
                end
            end
            S_POP:
            begin
                res_fire   = 1'b1;
                res_status = ST_DEQ;
                res_data   = outbox_rdata;
            end
            S_EMIT:
            begin
                res_fire   = 1'b1;
                res_status = pend_status_reg;
                res_data   = pend_data_reg;
            end
            default:
            begin
                res_fire = 1'b0;
            end
        endcase
        load_out  = res_fire && slot_free;
        load_pend = res_fire && !slot_free;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
        end
        if (load_pend)
        begin
            pend_status_reg <= res_status;
            pend_data_reg   <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_data_reg;

    a_in_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_cnt_reg <= cnt_t'(STACK_DEPTH))
        else $error("inbox count exceeds the stack depth");

    a_out_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= cnt_t'(STACK_DEPTH))
        else $error("outbox count exceeds the stack depth");

    a_emit_needs_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> out_valid_reg)
        else $error("result held back while the output register is free");

    a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_DEQ && out_cnt_reg != '0) |=>
            (state_reg == S_POP && out_cnt_reg == $past(out_cnt_reg) - 1'b1))
        else $error("dequeue from a filled outbox did not pop it");

endmodule

`default_nettype wire

// ----- hw/rtl/two_stack_queue.sv -----
// Results: enqueue and overflow results go to the output register, or to a pending
// register while it is held; a dequeue from a filled outbox passes through S_POP; one
// that refills the outbox moves the newer inbox values in S_XFER, one inbox read and outbox
// write per cycle. Throughput: one enqueue per cycle while the output is free or taken;
// no new request is taken during a dequeue. Reset: both counts and the handshake clear
// asynchronously; stack memories are not cleared, and in_ready is high once reset ends.
`default_nettype none

module two_stack_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                func,
    input  wire logic signed [31:0]  value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               status,
    output logic signed [31:0]       data_out
);
    import tsq_pkg::*;

    mem_req_t inbox_req;
    mem_req_t outbox_req;
    word_t    inbox_rdata;
    word_t    outbox_rdata;

    tsq_ram u_inbox (
        .clk   (clk),
        .req   (inbox_req),
        .rdata (inbox_rdata)
    );

    tsq_ram u_outbox (
        .clk   (clk),
        .req   (outbox_req),
        .rdata (outbox_rdata)
    );

    tsq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .data_out     (data_out),
        .inbox_req    (inbox_req),
        .inbox_rdata  (inbox_rdata),
        .outbox_req   (outbox_req),
        .outbox_rdata (outbox_rdata)
    );

endmodule

`default_nettype wire
